>>> src/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned TotalW = 61;
  localparam int unsigned WinLen = 16;

  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [5:0] BlockLast = 6'd63;
  localparam logic [5:0] LenStart  = 6'd56;
  localparam logic [5:0] RoundLast = 6'd63;
  localparam logic [2:0] WordLast  = 3'd7;
  localparam logic [7:0] PadMark   = 8'h80;

  localparam logic [WordW-1:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WordW-1:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LOAD,
    ST_ROUND,
    ST_ADD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic [2:0]       word_index;
    logic             last_word;
  } out_rsp_t;

  typedef struct packed {
    logic       shift_byte;
    logic [7:0] byte_val;
    logic       start_blk;
    logic       round_en;
    logic [5:0] round_idx;
    logic       add_hash;
    logic       rotate;
    logic       init_hash;
  } ctrl_t;

  function automatic logic [WordW-1:0] bsig0(input logic [WordW-1:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [WordW-1:0] bsig1(input logic [WordW-1:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [WordW-1:0] ssig0(input logic [WordW-1:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] ssig1(input logic [WordW-1:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
  endfunction

  function automatic logic [WordW-1:0] ch_fn(input logic [WordW-1:0] x,
                                             input logic [WordW-1:0] y,
                                             input logic [WordW-1:0] z);
    return (x & y) ^ (~x & z);
  endfunction

  function automatic logic [WordW-1:0] maj_fn(input logic [WordW-1:0] x,
                                              input logic [WordW-1:0] y,
                                              input logic [WordW-1:0] z);
    return (x & y) ^ (x & z) ^ (y & z);
  endfunction

endpackage

>>> src/sha256_sched.sv
// Message window: byte loader and rolling 16-word schedule expansion.
module sha256_sched import sha256_pkg::*; (
  input  logic             clk_i,
  input  ctrl_t            ctrl_i,
  output logic [WordW-1:0] w_o
);

  logic [WordW-1:0] win_q [WinLen];
  logic [WordW-1:0] win_d [WinLen];
  logic [WordW-1:0] w_new;

  assign w_new = ssig1(win_q[1]) + win_q[6] + ssig0(win_q[14]) + win_q[15];
  assign w_o   = win_q[15];

  always_comb begin
    for (int i = 0; i < WinLen; i++) begin
      win_d[i] = win_q[i];
    end
    if (ctrl_i.shift_byte) begin
      win_d[0] = {win_q[0][23:0], ctrl_i.byte_val};
      for (int i = 1; i < WinLen; i++) begin
        win_d[i] = {win_q[i][23:0], win_q[i-1][31:24]};
      end
    end else if (ctrl_i.round_en) begin
      win_d[0] = w_new;
      for (int i = 1; i < WinLen; i++) begin
        win_d[i] = win_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < WinLen; i++) begin
      win_q[i] <= win_d[i];
    end
  end

endmodule

>>> src/sha256_core.sv
// Round unit: working variables, chaining hash and digest word rotation.
module sha256_core import sha256_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctrl_t            ctrl_i,
  input  logic [WordW-1:0] w_i,
  output logic [WordW-1:0] digest_o
);

  logic [WordW-1:0] work_q [8];
  logic [WordW-1:0] work_d [8];
  logic [WordW-1:0] hash_q [8];
  logic [WordW-1:0] hash_d [8];
  logic [WordW-1:0] t1;
  logic [WordW-1:0] t2;

  assign t1 = work_q[7] + bsig1(work_q[4]) + ch_fn(work_q[4], work_q[5], work_q[6]) +
              RoundK[ctrl_i.round_idx] + w_i;
  assign t2 = bsig0(work_q[0]) + maj_fn(work_q[0], work_q[1], work_q[2]);

  assign digest_o = hash_q[0];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      work_d[i] = work_q[i];
    end
    if (ctrl_i.start_blk) begin
      for (int i = 0; i < 8; i++) begin
        work_d[i] = hash_q[i];
      end
    end else if (ctrl_i.round_en) begin
      work_d[0] = t1 + t2;
      work_d[1] = work_q[0];
      work_d[2] = work_q[1];
      work_d[3] = work_q[2];
      work_d[4] = work_q[3] + t1;
      work_d[5] = work_q[4];
      work_d[6] = work_q[5];
      work_d[7] = work_q[6];
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hash_d[i] = hash_q[i];
    end
    if (ctrl_i.init_hash) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = InitHash[i];
      end
    end else if (ctrl_i.add_hash) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[i] + work_q[i];
      end
    end else if (ctrl_i.rotate) begin
      for (int i = 0; i < 8; i++) begin
        hash_d[i] = hash_q[3'(i + 1)];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 8; i++) begin
      work_q[i] <= work_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= InitHash[i];
      end
    end else begin
      for (int i = 0; i < 8; i++) begin
        hash_q[i] <= hash_d[i];
      end
    end
  end

endmodule

>>> src/sha256_ctrl.sv
// Sequencer: request intake, padding, round counting and digest emission.
module sha256_ctrl import sha256_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  in_req_t in_req_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output logic [2:0] word_idx_o,
  output ctrl_t   ctrl_o
);

  state_e             state_q, state_d;
  logic [5:0]         pending_q, pending_d;
  logic [TotalW-1:0]  total_q, total_d;
  logic [5:0]         round_q, round_d;
  logic [2:0]         word_q, word_d;
  logic               first_q, first_d;
  logic               fit_q, fit_d;
  logic               final_q, final_d;
  logic               pad_q, pad_d;
  logic [63:0]        bit_len;
  logic [5:0]         len_shamt;
  logic [7:0]         len_byte;
  logic [7:0]         pad_byte;

  assign bit_len   = {total_q, 3'b000};
  assign len_shamt = {~pending_q[2:0], 3'b000};
  assign len_byte  = 8'(bit_len >> len_shamt);
  assign word_idx_o = word_q;

  always_comb begin
    priority if (first_q) begin
      pad_byte = PadMark;
    end else if (fit_q && (pending_q >= LenStart)) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_d     = state_q;
    pending_d   = pending_q;
    total_d     = total_q;
    round_d     = round_q;
    word_d      = word_q;
    first_d     = first_q;
    fit_d       = fit_q;
    final_d     = final_q;
    pad_d       = pad_q;
    ctrl_o      = '0;
    ctrl_o.round_idx = round_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_req_i.op == OP_ABSORB) begin
            ctrl_o.shift_byte = 1'b1;
            ctrl_o.byte_val   = in_req_i.data_byte;
            pending_d = pending_q + 6'd1;
            total_d   = total_q + TotalW'(1);
            pad_d     = 1'b0;
            if (pending_q == BlockLast) begin
              state_d = ST_LOAD;
            end
          end else begin
            state_d = ST_PAD;
            first_d = 1'b1;
            fit_d   = 1'b0;
            final_d = 1'b0;
            pad_d   = 1'b1;
          end
        end
      end
      ST_PAD: begin
        ctrl_o.shift_byte = 1'b1;
        ctrl_o.byte_val   = pad_byte;
        pending_d = pending_q + 6'd1;
        first_d   = 1'b0;
        if (first_q && (pending_q < LenStart)) begin
          fit_d = 1'b1;
        end
        if (pending_q == BlockLast) begin
          if (fit_q) begin
            final_d = 1'b1;
          end else begin
            fit_d = 1'b1;
          end
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ctrl_o.start_blk = 1'b1;
        round_d = 6'd0;
        state_d = ST_ROUND;
      end
      ST_ROUND: begin
        ctrl_o.round_en = 1'b1;
        round_d = round_q + 6'd1;
        if (round_q == RoundLast) begin
          state_d = ST_ADD;
        end
      end
      ST_ADD: begin
        ctrl_o.add_hash = 1'b1;
        priority if (!pad_q) begin
          state_d = ST_IDLE;
        end else if (final_q) begin
          word_d  = 3'd0;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_PAD;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          ctrl_o.rotate = 1'b1;
          word_d = word_q + 3'd1;
          if (word_q == WordLast) begin
            ctrl_o.init_hash = 1'b1;
            total_d   = '0;
            pending_d = '0;
            pad_d     = 1'b0;
            final_d   = 1'b0;
            state_d   = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pending_q <= '0;
      total_q   <= '0;
      round_q   <= '0;
      word_q    <= '0;
      first_q   <= 1'b0;
      fit_q     <= 1'b0;
      final_q   <= 1'b0;
      pad_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
      total_q   <= total_d;
      round_q   <= round_d;
      word_q    <= word_d;
      first_q   <= first_d;
      fit_q     <= fit_d;
      final_q   <= final_d;
      pad_q     <= pad_d;
    end
  end

`ifndef ASSERT_OFF
  a_ready_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("intake and digest output active together");

  a_emit_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (pending_q == 6'd0))
    else $error("digest output with bytes pending");

  a_round_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |=> ((state_q == ST_ROUND) && (round_q == 6'd0)))
    else $error("compression did not start at round zero");

  a_final_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_q |-> (fit_q && pad_q))
    else $error("final block marked without length placement");
`endif

endmodule

>>> src/sha256_stream_hasher.sv
// SHA-256 stream hasher top level: byte intake, padding and digest output.
// Absorb request: one byte into the window; the 64th byte of a block starts compression.
// Compression: a load step, 64 rounds on the single shared round unit, 1 hash add.
// Finish: one padding byte per cycle to the block end, then each padded block is compressed,
// then eight digest words, one per accepted cycle. Intake is not ready during compression.
// Reset: hash at the initial values, byte and length counters zero, ready for intake.
module sha256_stream_hasher import sha256_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output out_rsp_t out_rsp_o
);

  ctrl_t            ctrl;
  logic [WordW-1:0] w_cur;
  logic [WordW-1:0] digest;
  logic [2:0]       word_idx;

  sha256_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .word_idx_o  (word_idx),
    .ctrl_o      (ctrl)
  );

  sha256_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (ctrl),
    .w_o    (w_cur)
  );

  sha256_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .w_i      (w_cur),
    .digest_o (digest)
  );

  always_comb begin
    out_rsp_o.digest_word = digest;
    out_rsp_o.word_index  = word_idx;
    out_rsp_o.last_word   = (word_idx == WordLast);
  end

endmodule
